### hdl/tspq_pkg.sv
// ----------------------------------------------------------------------------
// Tube solid point query package
// Shared widths, constants, register codes and pipeline payload types.
// ----------------------------------------------------------------------------
package tspq_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int SCALE_W   = 8 + FRAC_W;
	localparam int RAD_W     = COORD_W - 1;
	localparam int TOL_W     = 16;
	localparam int SAFE_W    = 31;
	localparam int NORM_W    = 16;
	localparam int ROOT_W    = 32;
	localparam int SUM_W     = 64;
	localparam int PROD_W    = COORD_W + SCALE_W;
	localparam int QUOT_W    = 15;
	localparam int NUM_W     = 49;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int LATENCY   = 52;

	localparam logic [QUOT_W-1:0] NORM_ONE  = 15'd16384;
	localparam logic [QUOT_W-1:0] NORM_DIAG = 15'd11585;
	localparam logic [SAFE_W-1:0] SAFE_MAX  = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		REG_INNER = 3'd0,
		REG_OUTER = 3'd1,
		REG_ZLO   = 3'd2,
		REG_ZHI   = 3'd3,
		REG_TOL   = 3'd4
	} reg_idx_t;

	// Payload carried alongside the square root stages
	typedef struct packed {
		logic                xs;
		logic                ys;
		logic [COORD_W-1:0]  xm;
		logic [COORD_W-1:0]  ym;
		logic [COORD_W-1:0]  dz;
		logic [COORD_W-1:0]  dzn;
		logic                nz_min;
		logic                zin;
		logic [PROD_W-1:0]   prod;
	} sq_pl_t;

	// Payload carried alongside the divider stages
	typedef struct packed {
		logic                in_tube;
		logic [SAFE_W-1:0]   s_in;
		logic [SAFE_W-1:0]   s_out;
		logic [SAFE_W-1:0]   s_out_sc;
		logic                on_surf;
		logic                edge_n;
		logic                radial_n;
		logic                nz_min;
		logic                neg_x;
		logic                neg_y;
		logic                r_zero;
		logic [DEN_W-1:0]    den;
	} dv_pl_t;

endpackage

### hdl/tube_solid_point_query_unit.sv
// ----------------------------------------------------------------------------
// Tube solid point query unit
// Measures each point against a cylindrical shell: insideness, safeties,
// outward normal and on-surface flag.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration goes through the APB port: inner radius, outer radius,
//   lower z, upper z and surface tolerance at byte addresses 0, 4, 8, 12, 16.
//   Write it only while no item is in flight.
//   An item (point_x/y/z, dz_scale) is taken at each clock edge where start
//   is high; busy never rises, so one item may follow another every cycle.
//   Its result appears on the result ports with done high for exactly one
//   cycle, in input order.
//   Throughput is one item per cycle: the radius square root takes one root
//   bit per stage over 32 stages and each normal component divider one
//   quotient bit per stage over 15 stages, all fully pipelined.
//   The receiver cannot hold results off, so nothing in the pipeline stalls.
//   Reset clears the valid bits and restores register defaults (tolerance
//   one LSB, everything else zero); items in flight are dropped.
// ----------------------------------------------------------------------------
module tube_solid_point_query_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            point_x,
	input  logic signed [31:0]            point_y,
	input  logic signed [31:0]            point_z,
	input  logic [23:0]                   dz_scale,
	output logic                          done,
	output logic                          inside_res,
	output logic [30:0]                   safety_inside,
	output logic [30:0]                   safety_outside,
	output logic [30:0]                   safety_outside_scaled,
	output logic signed [15:0]            normal_x,
	output logic signed [15:0]            normal_y,
	output logic signed [15:0]            normal_z,
	output logic                          on_surface
);

	localparam int CW = tspq_pkg::COORD_W;
	localparam int RW = tspq_pkg::ROOT_W;
	localparam int QW = tspq_pkg::QUOT_W;
	localparam int NW = tspq_pkg::NUM_W;
	localparam int DW = tspq_pkg::DEN_W;
	localparam int SW = tspq_pkg::SAFE_W;

	// ---------------------------------------------------------------- config
	logic [tspq_pkg::RAD_W-1:0] inner_q, outer_q;
	logic signed [CW-1:0]       zlo_q, zhi_q;
	logic [tspq_pkg::TOL_W-1:0] tol_q;
	tspq_pkg::reg_idx_t         reg_idx;
	logic                       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = tspq_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			outer_q <= '0;
			zlo_q   <= '0;
			zhi_q   <= '0;
			tol_q   <= 16'd1;
		end else if (cfg_wr) begin
			case (reg_idx)
				tspq_pkg::REG_INNER: inner_q <= pwdata[30:0];
				tspq_pkg::REG_OUTER: outer_q <= pwdata[30:0];
				tspq_pkg::REG_ZLO:   zlo_q   <= pwdata;
				tspq_pkg::REG_ZHI:   zhi_q   <= pwdata;
				tspq_pkg::REG_TOL:   tol_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tspq_pkg::REG_INNER: prdata = {1'b0, inner_q};
			tspq_pkg::REG_OUTER: prdata = {1'b0, outer_q};
			tspq_pkg::REG_ZLO:   prdata = zlo_q;
			tspq_pkg::REG_ZHI:   prdata = zhi_q;
			tspq_pkg::REG_TOL:   prdata = {16'd0, tol_q};
			default:             prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// ------------------------------------------------- stage 1: input capture
	logic                  v_s1;
	logic                  xs_s1, ys_s1;
	logic [CW-1:0]         xm_s1, ym_s1;
	logic signed [CW-1:0]  z_s1;
	logic [23:0]           sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		xs_s1 <= point_x[CW-1];
		ys_s1 <= point_y[CW-1];
		xm_s1 <= point_x[CW-1] ? (~point_x + 32'd1) : point_x;
		ym_s1 <= point_y[CW-1] ? (~point_y + 32'd1) : point_y;
		z_s1  <= point_z;
		sc_s1 <= dz_scale;
	end

	// ----------------------------------- stage 2: squares and z wall distances
	logic signed [CW:0] dlo, dhi;
	logic [CW-1:0]      dzlo, dzhi, dz_c;

	always_comb begin
		dlo  = {z_s1[CW-1], z_s1} - {zlo_q[CW-1], zlo_q};
		dhi  = {z_s1[CW-1], z_s1} - {zhi_q[CW-1], zhi_q};
		dzlo = dlo[CW] ? CW'(-dlo) : dlo[CW-1:0];
		dzhi = dhi[CW] ? CW'(-dhi) : dhi[CW-1:0];
		if (dlo[CW])                    dz_c = dzlo;
		else if (!dhi[CW] && dhi != '0) dz_c = dzhi;
		else                            dz_c = '0;
	end

	logic                   v_s2;
	logic [2*CW-1:0]        sqx_s2, sqy_s2;
	logic                   xs_s2, ys_s2, nzmin_s2, zin_s2;
	logic [CW-1:0]          xm_s2, ym_s2, dz_s2, dzn_s2;
	logic [23:0]            sc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		sqx_s2   <= xm_s1 * xm_s1;
		sqy_s2   <= ym_s1 * ym_s1;
		xs_s2    <= xs_s1;
		ys_s2    <= ys_s1;
		xm_s2    <= xm_s1;
		ym_s2    <= ym_s1;
		dz_s2    <= dz_c;
		nzmin_s2 <= dzlo < dzhi;
		dzn_s2   <= (dzlo < dzhi) ? dzlo : dzhi;
		zin_s2   <= !dlo[CW] && dlo != '0 && dhi[CW];
		sc_s2    <= sc_s1;
	end

	// -------------------- stage 3: radius squared sum and scaled z excess
	// Element 0 of the root pipeline is this stage.
	logic              sqv_s [0:RW];
	logic [63:0]       sqrem_s [0:RW];
	logic [RW-1:0]     sqroot_s [0:RW];
	tspq_pkg::sq_pl_t  sqpl_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqv_s[0] <= 1'b0;
		else         sqv_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		sqrem_s[0]       <= sqx_s2 + sqy_s2;
		sqroot_s[0]      <= '0;
		sqpl_s[0].xs     <= xs_s2;
		sqpl_s[0].ys     <= ys_s2;
		sqpl_s[0].xm     <= xm_s2;
		sqpl_s[0].ym     <= ym_s2;
		sqpl_s[0].dz     <= dz_s2;
		sqpl_s[0].dzn    <= dzn_s2;
		sqpl_s[0].nz_min <= nzmin_s2;
		sqpl_s[0].zin    <= zin_s2;
		sqpl_s[0].prod   <= dz_s2 * sc_s2;
	end

	// ------------------------------------ square root: one root bit per stage
	for (genvar i = 1; i <= RW; i++) begin : g_sqrt
		localparam int B = RW - i;
		logic [65:0] trial;
		logic        take;

		always_comb begin
			trial = ({34'd0, sqroot_s[i-1]} << (B + 1)) | (66'd1 << (2 * B));
			take  = {2'b00, sqrem_s[i-1]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[i] <= 1'b0;
			else         sqv_s[i] <= sqv_s[i-1];
		end

		always_ff @(posedge clk) begin
			sqrem_s[i]  <= take ? (sqrem_s[i-1] - trial[63:0]) : sqrem_s[i-1];
			sqroot_s[i] <= take ? (sqroot_s[i-1] | (RW'(1) << B)) : sqroot_s[i-1];
			sqpl_s[i]   <= sqpl_s[i-1];
		end
	end

	// ----------------- post-root stage: radial tests, safeties, normal setup
	logic [RW-1:0]        r_c;
	tspq_pkg::sq_pl_t     pp;
	logic [CW:0]          r33, ri33, ro33, drin, drout, drn, dr;
	logic                 nr_in, inside_c, edge_c, radial_c, onsurf_c;
	logic [CW:0]          m_in, m_out, m_sc, scaled;
	logic [CW+QW-1:0]     px, py, pxd, pyd, pxo, pyo;

	function automatic logic [SW-1:0] sat31(input logic [CW:0] v);
		return (v > {2'b00, tspq_pkg::SAFE_MAX}) ? tspq_pkg::SAFE_MAX : v[SW-1:0];
	endfunction

	always_comb begin
		r_c   = sqroot_s[RW];
		pp    = sqpl_s[RW];
		r33   = {1'b0, r_c};
		ri33  = {2'b00, inner_q};
		ro33  = {2'b00, outer_q};
		drin  = (r33 >= ri33) ? r33 - ri33 : ri33 - r33;
		drout = (r33 >= ro33) ? r33 - ro33 : ro33 - r33;
		nr_in = drin < drout;
		drn   = nr_in ? drin : drout;
		if (r33 < ri33)      dr = ri33 - r33;
		else if (r33 > ro33) dr = r33 - ro33;
		else                 dr = '0;
		inside_c = pp.zin && (ri33 < r33) && (r33 < ro33);
		if (pp.prod[tspq_pkg::PROD_W-1:CW+tspq_pkg::FRAC_W] != '0)
			scaled = {1'b0, {CW{1'b1}}};
		else
			scaled = {1'b0, pp.prod[CW+tspq_pkg::FRAC_W-1:tspq_pkg::FRAC_W]};
		m_in  = (drn > {1'b0, pp.dzn}) ? drn : {1'b0, pp.dzn};
		m_out = (dr > {1'b0, pp.dz}) ? dr : {1'b0, pp.dz};
		m_sc  = (dr > scaled) ? dr : scaled;
		onsurf_c = (pp.dzn < {16'd0, tol_q}) || (drn < {17'd0, tol_q});
		edge_c   = (pp.dzn < {16'd0, tol_q}) && (drn < {17'd0, tol_q});
		radial_c = !edge_c && (drn < {1'b0, pp.dzn});
		// Form both scaled coordinates in parallel with the wall tests
		pxd      = pp.xm * tspq_pkg::NORM_DIAG;
		pyd      = pp.ym * tspq_pkg::NORM_DIAG;
		pxo      = pp.xm * tspq_pkg::NORM_ONE;
		pyo      = pp.ym * tspq_pkg::NORM_ONE;
		px       = edge_c ? pxd : pxo;
		py       = edge_c ? pyd : pyo;
	end

	// Element 0 of the divider pipeline is the post-root register.
	logic              dv_s [0:QW];
	logic [NW-1:0]     remx_s [0:QW];
	logic [NW-1:0]     remy_s [0:QW];
	logic [QW-1:0]     qx_s [0:QW];
	logic [QW-1:0]     qy_s [0:QW];
	tspq_pkg::dv_pl_t  dpl_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_s[0] <= 1'b0;
		else         dv_s[0] <= sqv_s[RW];
	end

	always_ff @(posedge clk) begin
		remx_s[0]          <= {1'b0, px, 1'b0} + NW'(r_c);
		remy_s[0]          <= {1'b0, py, 1'b0} + NW'(r_c);
		qx_s[0]            <= '0;
		qy_s[0]            <= '0;
		dpl_s[0].in_tube   <= inside_c;
		dpl_s[0].s_in      <= inside_c ? sat31(m_in) : '0;
		dpl_s[0].s_out     <= sat31(m_out);
		dpl_s[0].s_out_sc  <= sat31(m_sc);
		dpl_s[0].on_surf   <= onsurf_c;
		dpl_s[0].edge_n    <= edge_c;
		dpl_s[0].radial_n  <= radial_c;
		dpl_s[0].nz_min    <= pp.nz_min;
		dpl_s[0].neg_x     <= pp.xs ^ nr_in;
		dpl_s[0].neg_y     <= pp.ys ^ nr_in;
		dpl_s[0].r_zero    <= r_c == '0;
		dpl_s[0].den       <= {r_c, 1'b0};
	end

	// ------------------- normal component dividers: one quotient bit per stage
	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int B = QW - j;
		logic [NW-1:0] dsub;

		assign dsub = NW'(dpl_s[j-1].den) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[j] <= 1'b0;
			else         dv_s[j] <= dv_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (remx_s[j-1] >= dsub) begin
				remx_s[j] <= remx_s[j-1] - dsub;
				qx_s[j]   <= qx_s[j-1] | (QW'(1) << B);
			end else begin
				remx_s[j] <= remx_s[j-1];
				qx_s[j]   <= qx_s[j-1];
			end
			if (remy_s[j-1] >= dsub) begin
				remy_s[j] <= remy_s[j-1] - dsub;
				qy_s[j]   <= qy_s[j-1] | (QW'(1) << B);
			end else begin
				remy_s[j] <= remy_s[j-1];
				qy_s[j]   <= qy_s[j-1];
			end
			dpl_s[j] <= dpl_s[j-1];
		end
	end

	// ---------------------------------------------- output stage: sign, select
	tspq_pkg::dv_pl_t  fp;
	logic [15:0]       qx16, qy16, nx_c, ny_c, nz_c, zmag;

	always_comb begin
		fp   = dpl_s[QW];
		qx16 = {1'b0, qx_s[QW]};
		qy16 = {1'b0, qy_s[QW]};
		zmag = fp.edge_n ? {1'b0, tspq_pkg::NORM_DIAG} : {1'b0, tspq_pkg::NORM_ONE};
		if ((fp.edge_n || fp.radial_n) && !fp.r_zero) begin
			nx_c = fp.neg_x ? (~qx16 + 16'd1) : qx16;
			ny_c = fp.neg_y ? (~qy16 + 16'd1) : qy16;
		end else begin
			nx_c = '0;
			ny_c = '0;
		end
		if (fp.radial_n) nz_c = '0;
		else             nz_c = fp.nz_min ? (~zmag + 16'd1) : zmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_s[QW];
	end

	always_ff @(posedge clk) begin
		inside_res            <= fp.in_tube;
		safety_inside         <= fp.s_in;
		safety_outside        <= fp.s_out;
		safety_outside_scaled <= fp.s_out_sc;
		normal_x              <= nx_c;
		normal_y              <= ny_c;
		normal_z              <= nz_c;
		on_surface            <= fp.on_surf;
	end

	// -------------------------------------------------------------- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(tspq_pkg::LATENCY) done)
		else $error("item did not emerge after the pipeline latency");

	a_inside_no_excess: assert property (@(posedge clk) disable iff (!arst_n)
		done && inside_res |-> safety_outside == '0 && safety_outside_scaled == '0)
		else $error("inside point reported an outside excess");

	a_outside_no_safety: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_res |-> safety_inside == '0)
		else $error("outside point reported an inside safety");

	a_edge_on_surface: assert property (@(posedge clk) disable iff (!arst_n)
		done && (normal_z == 16'sd11585 || normal_z == -16'sd11585) |-> on_surface)
		else $error("edge normal without on-surface flag");

endmodule
